[sv/gab_pkg.sv]
// Shared constants and table builders for the gamma-correct alpha blender.
`default_nettype none
package gab_pkg;

  localparam int LINEAR_FRAC_BITS_DEF = 16;

  localparam int PIX_W    = 32;
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 4;   // blue, green, red, alpha
  localparam int ALPHA_CH = 3;
  localparam int COLOR_CH = 3;

  localparam int GA_W    = 17;
  localparam int GA_FRAC = 16;
  localparam int GA_ONE  = 65536;
  localparam int GA_HALF = 32768;

  // 4 * 255^2, scale of the square-root compare
  localparam int SRGB_RHS = 260100;
  localparam int QW       = 20;  // width of the integer compare operand
  localparam int SQ_BITS  = 9;   // result bits searched by the root pipeline
  localparam int CH_MAX   = 255;

  // round(c*c * 2^f / 65025)
  function automatic longint lin_color_val(input int c, input int f);
    longint x;
    x = (longint'(c) * longint'(c)) << f;
    return (2 * x + 65025) / 130050;
  endfunction

  // round(a * 2^f / 255)
  function automatic longint lin_alpha_val(input int a, input int f);
    longint x;
    x = longint'(a) << f;
    return (2 * x + 255) / 510;
  endfunction

endpackage
`default_nettype wire

[sv/gab_linearize.sv]
// Linearisation tables and global alpha scaling (two register stages).
`default_nettype none
module gab_linearize import gab_pkg::*; #(
  parameter int F = LINEAR_FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [PIX_W-1:0]    source_pixel,
  input  wire logic [PIX_W-1:0]    dest_pixel,
  input  wire logic [GA_W-1:0]     ga,
  output logic                     out_valid,
  output logic [F:0]               src_lin [NUM_CH],
  output logic [F:0]               dst_lin [NUM_CH]
);

  localparam int LW = F + 1;
  localparam int PW = LW + GA_W;

  logic [LW-1:0] col_tab [256];
  logic [LW-1:0] alp_tab [256];

  for (genvar i = 0; i < 256; i++) begin : g_tab
    localparam logic [LW-1:0] ColV = LW'(lin_color_val(i, F));
    localparam logic [LW-1:0] AlpV = LW'(lin_alpha_val(i, F));
    assign col_tab[i] = ColV;
    assign alp_tab[i] = AlpV;
  end

  // stage A: table lookups
  logic          a_valid;
  logic [LW-1:0] a_src [NUM_CH];
  logic [LW-1:0] a_dst [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < COLOR_CH; i++) begin
        a_src[i] <= col_tab[source_pixel[CH_W*i +: CH_W]];
        a_dst[i] <= col_tab[dest_pixel[CH_W*i +: CH_W]];
      end
      a_src[ALPHA_CH] <= alp_tab[source_pixel[CH_W*ALPHA_CH +: CH_W]];
      a_dst[ALPHA_CH] <= alp_tab[dest_pixel[CH_W*ALPHA_CH +: CH_W]];
    end
  end

  // stage B: source times global alpha, rounded
  logic [PW-1:0] prod [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      prod[i] = PW'(a_src[i]) * PW'(ga) + PW'(GA_HALF);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_CH; i++) begin
        src_lin[i] <= prod[i][LW+GA_FRAC-1:GA_FRAC];
        dst_lin[i] <= a_dst[i];
      end
    end
  end

endmodule
`default_nettype wire

[sv/gab_mix.sv]
// Over operator and root-operand scaling (three register stages).
`default_nettype none
module gab_mix import gab_pkg::*; #(
  parameter int F = LINEAR_FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire logic [F:0]     src_lin [NUM_CH],
  input  wire logic [F:0]     dst_lin [NUM_CH],
  output logic                out_valid,
  output logic [QW-1:0]       q [COLOR_CH],
  output logic [CH_W-1:0]     alpha
);

  localparam int LW = F + 1;
  localparam int RW = F + 2;
  localparam int MW = 2 * LW;
  localparam int SW = RW + 18;
  localparam int AW = RW + 8;

  localparam logic [LW-1:0] ONE    = {1'b1, {F{1'b0}}};
  localparam logic [MW-1:0] HALF_M = MW'(1) << (F - 1);
  localparam logic [AW-1:0] HALF_A = AW'(1) << (F - 1);

  // stage C: one minus source alpha
  logic          c_valid;
  logic [LW-1:0] c_inv;
  logic [LW-1:0] c_src [NUM_CH];
  logic [LW-1:0] c_dst [NUM_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= in_valid;
    end
  end

  // scaled alpha never exceeds one, so no clamp needed
  always_ff @(posedge clk) begin
    if (en) begin
      c_inv <= ONE - src_lin[ALPHA_CH];
      c_src <= src_lin;
      c_dst <= dst_lin;
    end
  end

  // stage D: inv * dst, rounded, plus source
  logic          d_valid;
  logic [RW-1:0] d_res [NUM_CH];
  logic [MW-1:0] mp    [NUM_CH];

  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      mp[i] = MW'(c_inv) * MW'(c_dst[i]) + HALF_M;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_CH; i++) begin
        d_res[i] <= mp[i][MW-1:F] + RW'(c_src[i]);
      end
    end
  end

  // stage E: root operand floor(260100*r / 2^F); alpha back to 8 bits
  logic [SW-1:0] rhs [COLOR_CH];
  logic [AW-1:0] av;

  always_comb begin
    for (int i = 0; i < COLOR_CH; i++) begin
      rhs[i] = SW'(d_res[i]) * SW'(SRGB_RHS);
    end
    av = AW'(d_res[ALPHA_CH]) * AW'(CH_MAX) + HALF_A;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < COLOR_CH; i++) begin
        q[i] <= rhs[i][F+QW-1:F];
      end
      alpha <= (|av[AW-1:F+CH_W]) ? CH_W'(CH_MAX) : av[F+CH_W-1:F];
    end
  end

endmodule
`default_nettype wire

[sv/gab_sqrt.sv]
// Bit-per-stage square root search for the colour channels, packs the pixel.
`default_nettype none
module gab_sqrt import gab_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [QW-1:0]    q [COLOR_CH],
  input  wire logic [CH_W-1:0]  alpha,
  output logic                  tail_valid,
  output logic [PIX_W-1:0]      tail_pixel
);

  localparam int NB = SQ_BITS;
  localparam int KW = NB + 1;

  logic              vld [NB];
  logic [QW-1:0]     q_p [NB][COLOR_CH];
  logic [NB-1:0]     n_p [NB][COLOR_CH];
  logic [CH_W-1:0]   a_p [NB];

  for (genvar j = 0; j < NB; j++) begin : g_stage
    logic            vi;
    logic [QW-1:0]   qi [COLOR_CH];
    logic [NB-1:0]   ni [COLOR_CH];
    logic [CH_W-1:0] ai;
    logic [NB-1:0]   t  [COLOR_CH];
    logic [KW-1:0]   k  [COLOR_CH];
    logic [2*KW-1:0] sq [COLOR_CH];

    if (j == 0) begin : g_first
      assign vi = in_valid;
      assign qi = q;
      assign ai = alpha;
      for (genvar c = 0; c < COLOR_CH; c++) begin : g_zero
        assign ni[c] = '0;
      end
    end else begin : g_next
      assign vi = vld[j-1];
      assign qi = q_p[j-1];
      assign ni = n_p[j-1];
      assign ai = a_p[j-1];
    end

    // trial bit kept when (2t-1)^2 <= q
    always_comb begin
      for (int c = 0; c < COLOR_CH; c++) begin
        t[c]  = ni[c] | (NB'(1) << (NB - 1 - j));
        k[c]  = {t[c], 1'b0} - KW'(1);
        sq[c] = (2*KW)'(k[c]) * (2*KW)'(k[c]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < COLOR_CH; c++) begin
          n_p[j][c] <= (QW'(sq[c]) <= qi[c]) ? t[c] : ni[c];
        end
        q_p[j] <= qi;
        a_p[j] <= ai;
      end
    end
  end

  assign tail_valid = vld[NB-1];

  always_comb begin
    tail_pixel = '0;
    for (int c = 0; c < COLOR_CH; c++) begin
      tail_pixel[CH_W*c +: CH_W] = (|n_p[NB-1][c][NB-1:CH_W]) ? CH_W'(CH_MAX)
                                                               : n_p[NB-1][c][CH_W-1:0];
    end
    tail_pixel[CH_W*ALPHA_CH +: CH_W] = a_p[NB-1];
  end

endmodule
`default_nettype wire

[sv/gab_skid.sv]
// Output register with one skid entry; freezes the pipeline while the skid is full.
`default_nettype none
module gab_skid import gab_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tail_valid,
  input  wire logic [PIX_W-1:0] tail_pixel,
  output logic                  full,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [PIX_W-1:0]      blended_pixel
);

  logic             skid_data_valid;
  logic [PIX_W-1:0] skid_data;
  logic             take;

  assign take = out_valid & ~out_stall;
  assign full = skid_data_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      skid_data_valid <= 1'b0;
    end else if (skid_data_valid) begin
      if (take) begin
        out_valid       <= 1'b1;
        skid_data_valid <= 1'b0;
      end
    end else if (!out_valid || take) begin
      out_valid <= tail_valid;
    end else if (tail_valid) begin
      skid_data_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_data_valid) begin
      if (take) begin
        blended_pixel <= skid_data;
      end
    end else if (!out_valid || take) begin
      blended_pixel <= tail_pixel;
    end else begin
      skid_data <= tail_pixel;
    end
  end

endmodule
`default_nettype wire

[sv/gamma_alpha_blend_pixel_core.sv]
// Top level of the gamma-correct ARGB8888 alpha blender.
//
// Input channel: source_pixel and dest_pixel move on a transfer when
// in_valid is high and in_stall is low. Output channel: blended_pixel
// moves when out_valid is high and out_stall is low.
// global_alpha is written (Q1.16, values above 1.0 clamp to 1.0) when
// global_alpha_we is high; change it only with no pixel in flight.
//
// Throughput: one pixel per cycle while out_stall stays low. Path from
// the input transfer to out_valid: two stages linearise and scale, three
// mix and prepare the root operand, nine search the square root one
// result bit per stage, one output register.
//
// Reset (synchronous, rst high) empties the pipeline and the skid entry
// and sets global_alpha to 1.0.
// Receiver stall: the output register holds its pixel; the pixel behind it
// drops into a skid entry, and only when that entry is full does in_stall
// rise and the whole pipeline freeze. Nothing is dropped or duplicated.
`default_nettype none
module gamma_alpha_blend_pixel_core import gab_pkg::*; #(
  parameter int LINEAR_FRAC_BITS = LINEAR_FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // configuration
  input  wire logic             global_alpha_we,
  input  wire logic [GA_W-1:0]  global_alpha,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [PIX_W-1:0] source_pixel,
  input  wire logic [PIX_W-1:0] dest_pixel,
  // output channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [PIX_W-1:0]      blended_pixel
);

  localparam int F = LINEAR_FRAC_BITS;

  localparam logic [GA_W-1:0] GA_ONE_V = GA_W'(GA_ONE);

  // global alpha register, clamped on write
  logic [GA_W-1:0] ga;

  always_ff @(posedge clk) begin
    if (rst) begin
      ga <= GA_ONE_V;
    end else if (global_alpha_we) begin
      ga <= (global_alpha > GA_ONE_V) ? GA_ONE_V : global_alpha;
    end
  end

  // one enable for every stage ahead of the skid: advance unless the skid entry is occupied
  logic skid_full;
  logic en;

  assign en       = ~skid_full;
  assign in_stall = skid_full;

  logic          lin_valid;
  logic [F:0]    src_lin [NUM_CH];
  logic [F:0]    dst_lin [NUM_CH];

  gab_linearize #(.F(F)) u_lin (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_valid),
    .source_pixel (source_pixel),
    .dest_pixel   (dest_pixel),
    .ga           (ga),
    .out_valid    (lin_valid),
    .src_lin      (src_lin),
    .dst_lin      (dst_lin)
  );

  logic            mix_valid;
  logic [QW-1:0]   root_q [COLOR_CH];
  logic [CH_W-1:0] mix_alpha;

  gab_mix #(.F(F)) u_mix (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (lin_valid),
    .src_lin   (src_lin),
    .dst_lin   (dst_lin),
    .out_valid (mix_valid),
    .q         (root_q),
    .alpha     (mix_alpha)
  );

  logic             tail_valid;
  logic [PIX_W-1:0] tail_pixel;

  gab_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (mix_valid),
    .q          (root_q),
    .alpha      (mix_alpha),
    .tail_valid (tail_valid),
    .tail_pixel (tail_pixel)
  );

  gab_skid u_skid (
    .clk           (clk),
    .rst           (rst),
    .tail_valid    (tail_valid),
    .tail_pixel    (tail_pixel),
    .full          (skid_full),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .blended_pixel (blended_pixel)
  );

endmodule
`default_nettype wire

[sv/gab_checker.sv]
// Port-level checks for the blender, bound to the top level.
`default_nettype none
module gab_checker import gab_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [PIX_W-1:0] blended_pixel
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(blended_pixel))
    else $error("stalled output changed");

  // reset leaves both sides empty and open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the pipeline");

  // back-pressure appears only behind a stalled output
  a_stall_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output stall");

  // back-pressure lifts only on an output transfer
  a_stall_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> $past(out_valid && !out_stall))
    else $error("input stall released without output transfer");

endmodule

bind gamma_alpha_blend_pixel_core gab_checker u_gab_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .blended_pixel (blended_pixel)
);
`default_nettype wire

[verif/gamma_alpha_blend_pixel_core_tb.sv]
// Self-checking testbench for the gamma-correct ARGB8888 alpha blender core.
`timescale 1ns / 100ps
module gamma_alpha_blend_pixel_core_tb;
  import gab_pkg::*;

  // Linear-light precision matches the core's default build.
  localparam int FRAC        = LINEAR_FRAC_BITS_DEF;
  localparam int LATENCY     = 15;
  localparam int SETTLE      = LATENCY + 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam int N_ROWS      = 17;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 64;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [GA_W-1:0]  opacity_t;
  typedef longint unsigned  lin_t;

  // One row of the directed list. Where known is set, want is the pixel
  // read straight off the blend equation; otherwise the predictor decides.
  typedef struct packed {
    pixel_t src;
    pixel_t dst;
    logic   known;
    pixel_t want;
  } blend_row_t;

  logic     clk             = 1'b0;
  logic     rst             = 1'b1;
  logic     global_alpha_we = 1'b0;
  opacity_t global_alpha    = '0;
  logic     in_valid        = 1'b0;
  logic     in_stall;
  pixel_t   source_pixel    = '0;
  pixel_t   dest_pixel      = '0;
  logic     out_valid;
  logic     out_stall       = 1'b0;
  pixel_t   blended_pixel;

  opacity_t opacity_now;      // our copy of global_alpha, already clamped
  pixel_t   blends_due[$];    // predicted pixels, oldest first
  int       mismatch_count = 0;
  int       cyc            = 0;
  int       rx_hold        = 0;

  // All rows below run with global alpha at its reset value of 1.0.
  blend_row_t directed_rows [N_ROWS] = '{
    // both pixels empty: nothing to blend
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
    // opaque white source hides any destination
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    // empty source leaves the destination alone
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    // additive colour with zero alpha
    '{32'h00FF_FFFF, 32'h0000_0000, 1'b1, 32'h00FF_FFFF},
    // channel overflow: full colour added to full colour clamps at 255
    '{32'h00FF_FFFF, 32'h00FF_FFFF, 1'b1, 32'h00FF_FFFF},
    '{32'h00FF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    // opaque sources hide the destination: black over white, green over magenta
    '{32'hFF00_0000, 32'hFFFF_FFFF, 1'b1, 32'hFF00_0000},
    '{32'hFF00_FF00, 32'h00FF_00FF, 1'b1, 32'hFF00_FF00},
    // the rest need the full arithmetic
    '{32'h0000_0000, 32'h1234_5678, 1'b0, 32'h0},
    '{32'h80FF_0000, 32'h0000_00FF, 1'b0, 32'h0},
    '{32'h0101_0101, 32'hFEFE_FEFE, 1'b0, 32'h0},
    '{32'h7F80_8080, 32'h807F_7F7F, 1'b0, 32'h0},
    '{32'hFF12_3456, 32'h9ABC_DEF0, 1'b0, 32'h0},
    '{32'h0001_0203, 32'h0000_0000, 1'b0, 32'h0},
    '{32'hAA55_AA55, 32'h55AA_55AA, 1'b0, 32'h0},
    '{32'h8000_0000, 32'hFF00_0000, 1'b0, 32'h0}
  };

  gamma_alpha_blend_pixel_core dut (
    .clk             (clk),
    .rst             (rst),
    .global_alpha_we (global_alpha_we),
    .global_alpha    (global_alpha),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .source_pixel    (source_pixel),
    .dest_pixel      (dest_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .blended_pixel   (blended_pixel)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Blend predictor. Linear values are Q2.FRAC; every step rounds half up.
  // ---------------------------------------------------------------------

  // (c/255)^2 in linear light
  function automatic lin_t color_to_linear(input chan_t c);
    lin_t x;
    x = (lin_t'(c) * lin_t'(c)) << FRAC;
    return (2 * x + CH_MAX * CH_MAX) / (2 * CH_MAX * CH_MAX);
  endfunction

  // a/255, no gamma on alpha
  function automatic lin_t alpha_to_linear(input chan_t a);
    lin_t x;
    x = lin_t'(a) << FRAC;
    return (2 * x + CH_MAX) / (2 * CH_MAX);
  endfunction

  // scale by the Q1.16 opacity
  function automatic lin_t apply_opacity(input lin_t v, input opacity_t ga);
    return (v * lin_t'(ga) + GA_HALF) >> GA_FRAC;
  endfunction

  // (1 - src alpha) * dst + src
  function automatic lin_t mix_channel(input lin_t inv, input lin_t d, input lin_t s);
    return ((inv * d + (lin_t'(1) << (FRAC - 1))) >> FRAC) + s;
  endfunction

  // 255*sqrt(r) rounded, found bit by bit with exact integer compares
  function automatic chan_t linear_to_color(input lin_t r);
    lin_t               rhs;
    lin_t               k;
    logic [SQ_BITS-1:0] n;
    logic [SQ_BITS-1:0] t;
    rhs = lin_t'(SRGB_RHS) * r;
    n   = '0;
    for (int b = SQ_BITS - 1; b >= 0; b--) begin
      t    = n;
      t[b] = 1'b1;
      k    = 2 * lin_t'(t) - 1;
      if (((k * k) << FRAC) <= rhs)
        n = t;
    end
    return (n > CH_MAX) ? chan_t'(CH_MAX) : n[CH_W-1:0];
  endfunction

  function automatic chan_t linear_to_alpha(input lin_t r);
    lin_t v;
    v = (CH_MAX * r + (lin_t'(1) << (FRAC - 1))) >> FRAC;
    return (v > CH_MAX) ? chan_t'(CH_MAX) : v[CH_W-1:0];
  endfunction

  // Whole-pixel blend; ga is the clamped register value.
  function automatic pixel_t blend_argb(input pixel_t src, input pixel_t dst,
                                        input opacity_t ga);
    lin_t   one;
    lin_t   sa;
    lin_t   inv;
    lin_t   s;
    lin_t   d;
    pixel_t res;
    one = lin_t'(1) << FRAC;
    sa  = apply_opacity(alpha_to_linear(src[ALPHA_CH*CH_W +: CH_W]), ga);
    inv = (sa >= one) ? lin_t'(0) : one - sa;
    res[ALPHA_CH*CH_W +: CH_W] =
      linear_to_alpha(mix_channel(inv, alpha_to_linear(dst[ALPHA_CH*CH_W +: CH_W]), sa));
    for (int ch = 0; ch < COLOR_CH; ch++) begin
      s = apply_opacity(color_to_linear(src[ch*CH_W +: CH_W]), ga);
      d = color_to_linear(dst[ch*CH_W +: CH_W]);
      res[ch*CH_W +: CH_W] = linear_to_color(mix_channel(inv, d, s));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly per-channel picks weighted towards the edges (0, 1, 254, 255,
  // mid-scale) so opaque/transparent alpha and saturation turn up often.
  function automatic pixel_t draw_pixel();
    pixel_t p;
    if ($urandom_range(0, 4) == 0)
      return pixel_t'($urandom());
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(0, 9))
        0:       p[ch*CH_W +: CH_W] = 8'h00;
        1:       p[ch*CH_W +: CH_W] = 8'hFF;
        2:       p[ch*CH_W +: CH_W] = 8'h01;
        3:       p[ch*CH_W +: CH_W] = 8'hFE;
        4:       p[ch*CH_W +: CH_W] = 8'h80;
        default: p[ch*CH_W +: CH_W] = chan_t'($urandom_range(0, CH_MAX));
      endcase
    end
    return p;
  endfunction

  // Present one pixel pair and hold it until the transfer; the prediction
  // is queued at the accepting edge, well ahead of the core's latency.
  task automatic send_pair(input pixel_t s, input pixel_t d,
                           input logic known, input pixel_t want);
    in_valid     <= 1'b1;
    source_pixel <= s;
    dest_pixel   <= d;
    do @(posedge clk); while (in_stall);
    blends_due.push_back(known ? want : blend_argb(s, d, opacity_now));
  endtask

  // Sender idle time after a transfer: mostly none or short, now and then
  // long, and a run of back-to-back transfers at the start of every 64.
  task automatic sender_gap(input int idx);
    int n;
    int r;
    r = $urandom_range(0, 99);
    if ((idx % 64) < 12 || r < 50)
      n = 0;
    else if (r < 92)
      n = $urandom_range(1, 3);
    else
      n = $urandom_range(8, 40);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stop sending and let every predicted pixel come out, plus a margin.
  task automatic drain();
    in_valid <= 1'b0;
    while (blends_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input pixel_t got, input pixel_t want);
    mismatch_count++;
    $display("[%0t] mismatch, %s: blended_pixel %08h, predicted %08h",
             $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall with calm stretches where it never stalls.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold   <= 0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if ((cyc % 2048) < 256) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          out_stall <= 1'b0;
          rx_hold   <= $urandom_range(0, 6);
        end
        11, 12, 13, 14, 15, 16, 17, 18: begin
          out_stall <= 1'b1;
          rx_hold   <= $urandom_range(0, 3);
        end
        default: begin
          out_stall <= 1'b1;
          rx_hold   <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  // Output check: each transfer against the oldest prediction.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (blends_due.size() == 0) begin
        report_mismatch("transfer with nothing predicted", blended_pixel, '0);
      end else begin
        want = blends_due.pop_front();
        if (blended_pixel !== want)
          report_mismatch("pixel", blended_pixel, want);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cyc == CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d pixels outstanding", $time, blends_due.size());
      $display("status: fail");
      $finish;
    end else begin
      cyc <= cyc + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    opacity_t phase_ga [N_PHASES];
    pixel_t   s;
    pixel_t   d;
    // phase 0 runs at the reset value; the rest cover zero, values above
    // one (clamped) such as the all-ones register, half, one LSB, one minus
    // one LSB, one itself and a couple of random settings
    phase_ga = '{opacity_t'(GA_ONE), 17'd0, 17'h1FFFF, opacity_t'(GA_HALF), 17'd1,
                 opacity_t'(GA_ONE - 1), opacity_t'(GA_ONE + 1), opacity_t'(GA_ONE),
                 17'd0, 17'd0};
    phase_ga[8] = opacity_t'($urandom_range(0, GA_ONE));
    phase_ga[9] = opacity_t'($urandom_range(0, 2 * GA_ONE - 1));
    opacity_now = opacity_t'(GA_ONE);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_pair(directed_rows[i].src, directed_rows[i].dst,
                directed_rows[i].known, directed_rows[i].want);
      sender_gap(i);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        // only touch global_alpha with the pipeline empty
        drain();
        global_alpha_we <= 1'b1;
        global_alpha    <= phase_ga[p];
        @(posedge clk);
        global_alpha_we <= 1'b0;
        opacity_now = (phase_ga[p] > GA_ONE) ? opacity_t'(GA_ONE) : phase_ga[p];
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        s = draw_pixel();
        d = draw_pixel();
        send_pair(s, d, 1'b0, '0);
        // occasionally hold off until the core has emptied
        if ($urandom_range(0, 149) == 0)
          drain();
        else
          sender_gap(i);
      end
    end

    drain();
    if (mismatch_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

[filelist.f]
sv/gab_pkg.sv
sv/gab_linearize.sv
sv/gab_mix.sv
sv/gab_sqrt.sv
sv/gab_skid.sv
sv/gamma_alpha_blend_pixel_core.sv
sv/gab_checker.sv
verif/gamma_alpha_blend_pixel_core_tb.sv
